>>> design/fbpa_pkg.sv
// Package for the fixed block pool allocator.
// Holds request codes, field widths and the item structs; no dependencies.

package fbpa_pkg;

    localparam int REQ_TYPE_W  = 2;
    localparam int REL_IDX_W   = 3;
    localparam int GRANT_IDX_W = 3;
    localparam int TOTAL_W     = 32;
    localparam int USAGE_W     = 4;

    localparam logic [REQ_TYPE_W-1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_RESET   = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [REL_IDX_W-1:0]  release_index;
    } req_t;

    typedef struct packed {
        logic                   granted;
        logic [GRANT_IDX_W-1:0] grant_index;
        logic [TOTAL_W-1:0]     acquired_total;
        logic [TOTAL_W-1:0]     released_total;
        logic [TOTAL_W-1:0]     exhausted_total;
        logic [USAGE_W-1:0]     in_use;
        logic [USAGE_W-1:0]     peak_in_use;
        logic [USAGE_W-1:0]     free_count;
    } rsp_t;

endpackage

>>> design/fbpa_req_if.sv
// Request channel of the fixed block pool allocator.
// Depends on fbpa_pkg for the field widths.

interface fbpa_req_if
    import fbpa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [REL_IDX_W-1:0]  release_index;

    modport source (output valid, req_type, release_index, input ready);
    modport sink   (input valid, req_type, release_index, output ready);
endinterface

>>> design/fbpa_rsp_if.sv
// Result channel of the fixed block pool allocator.
// Depends on fbpa_pkg for the field widths.

interface fbpa_rsp_if
    import fbpa_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   granted;
    logic [GRANT_IDX_W-1:0] grant_index;
    logic [TOTAL_W-1:0]     acquired_total;
    logic [TOTAL_W-1:0]     released_total;
    logic [TOTAL_W-1:0]     exhausted_total;
    logic [USAGE_W-1:0]     in_use;
    logic [USAGE_W-1:0]     peak_in_use;
    logic [USAGE_W-1:0]     free_count;

    modport source (output valid, granted, grant_index, acquired_total, released_total,
                    exhausted_total, in_use, peak_in_use, free_count, input ready);
    modport sink   (input valid, granted, grant_index, acquired_total, released_total,
                    exhausted_total, in_use, peak_in_use, free_count, output ready);
endinterface

>>> design/fbpa_find_free.sv
// Lowest-set-bit finder over the free bitmap.
// Standalone; used by fbpa_pool_state.

module fbpa_find_free #(
    parameter int POOL_COUNT = 8
) (
    input  logic [POOL_COUNT-1:0]                            free_map,
    output logic                                             found,
    output logic [POOL_COUNT-1:0]                            onehot,
    output logic [((POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1)-1:0] index
);
    localparam int IDX_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

    // Two's complement isolates the lowest set bit; the encoder then ORs
    // independent positions together.
    assign onehot = free_map & (~free_map + POOL_COUNT'(1));
    assign found  = |free_map;

    always_comb
    begin
        index = '0;
        for (int i = 0; i < POOL_COUNT; i++)
        begin
            if (onehot[i])
            begin
                index = index | IDX_W'(i);
            end
        end
    end
endmodule

>>> design/fbpa_pool_state.sv
// Pool state of the allocator: free bitmap, statistics counters and the
// per-request update. Depends on fbpa_pkg and fbpa_find_free.

module fbpa_pool_state
    import fbpa_pkg::*;
#(
    parameter int POOL_COUNT = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  req_t item,
    output rsp_t result
);
    localparam int IDX_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int CNT_W = $clog2(POOL_COUNT + 1);

    logic [POOL_COUNT-1:0] free_map_reg, free_map_next;
    logic [TOTAL_W-1:0]    acq_reg, acq_next;
    logic [TOTAL_W-1:0]    rel_reg, rel_next;
    logic [TOTAL_W-1:0]    exh_reg, exh_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [CNT_W-1:0]      peak_reg, peak_next;
    logic [CNT_W-1:0]      free_cnt_reg, free_cnt_next;

    logic                  found;
    logic [POOL_COUNT-1:0] first_free;
    logic [IDX_W-1:0]      first_idx;
    logic [POOL_COUNT-1:0] rel_bit;
    logic                  granted;
    logic [IDX_W-1:0]      grant_idx;

    fbpa_find_free #(
        .POOL_COUNT (POOL_COUNT)
    ) u_find_free (
        .free_map (free_map_reg),
        .found    (found),
        .onehot   (first_free),
        .index    (first_idx)
    );

    // An index beyond the pool shifts out and leaves an empty mask.
    assign rel_bit = POOL_COUNT'(1) << item.release_index;

    always_comb
    begin
        free_map_next = free_map_reg;
        acq_next      = acq_reg;
        rel_next      = rel_reg;
        exh_next      = exh_reg;
        used_next     = used_reg;
        peak_next     = peak_reg;
        free_cnt_next = free_cnt_reg;
        granted       = 1'b0;
        grant_idx     = '0;
        case (item.req_type)
            REQ_ACQUIRE:
            begin
                if (found)
                begin
                    free_map_next = free_map_reg & ~first_free;
                    granted       = 1'b1;
                    grant_idx     = first_idx;
                    acq_next      = acq_reg + TOTAL_W'(1);
                    used_next     = used_reg + CNT_W'(1);
                    free_cnt_next = free_cnt_reg - CNT_W'(1);
                    if (used_next > peak_reg)
                    begin
                        peak_next = used_next;
                    end
                end
                else
                begin
                    exh_next = exh_reg + TOTAL_W'(1);
                end
            end
            REQ_RELEASE:
            begin
                if ((rel_bit != '0) && ((free_map_reg & rel_bit) == '0))
                begin
                    free_map_next = free_map_reg | rel_bit;
                    rel_next      = rel_reg + TOTAL_W'(1);
                    free_cnt_next = free_cnt_reg + CNT_W'(1);
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - CNT_W'(1);
                    end
                end
            end
            REQ_RESET:
            begin
                free_map_next = '1;
                acq_next      = '0;
                rel_next      = '0;
                exh_next      = '0;
                used_next     = '0;
                peak_next     = '0;
                free_cnt_next = CNT_W'(POOL_COUNT);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.granted         = granted;
        result.grant_index     = GRANT_IDX_W'(grant_idx);
        result.acquired_total  = acq_next;
        result.released_total  = rel_next;
        result.exhausted_total = exh_next;
        result.in_use          = USAGE_W'(used_next);
        result.peak_in_use     = USAGE_W'(peak_next);
        result.free_count      = USAGE_W'(free_cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg <= '1;
            acq_reg      <= '0;
            rel_reg      <= '0;
            exh_reg      <= '0;
            used_reg     <= '0;
            peak_reg     <= '0;
            free_cnt_reg <= CNT_W'(POOL_COUNT);
        end
        else if (fire)
        begin
            free_map_reg <= free_map_next;
            acq_reg      <= acq_next;
            rel_reg      <= rel_next;
            exh_reg      <= exh_next;
            used_reg     <= used_next;
            peak_reg     <= peak_next;
            free_cnt_reg <= free_cnt_next;
        end
    end

    // Held and free buffers always account for the whole pool.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, used_reg} + {1'b0, free_cnt_reg}) == (CNT_W + 1)'(POOL_COUNT))
        else $error("held and free counts do not cover the pool");

    assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= used_reg)
        else $error("peak usage fell below current usage");

    assert property (@(posedge clk) disable iff (!rst_n)
        granted |-> (item.req_type == REQ_ACQUIRE) && (free_map_reg[grant_idx]))
        else $error("grant of a buffer that was not free");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.req_type == REQ_RESET)) |=> (free_map_reg == '1) && (acq_reg == '0))
        else $error("pool reset did not free every buffer");
endmodule

>>> design/fixed_block_pool_allocator_core.sv
// Fixed block pool allocator: each request passes through the input register, then the
// result register, on its way to the result transfer.
// One request is taken every cycle; the result register and the input register
// advance together, so a waiting result stalls intake only when both are full.
// Reset (rst_n low) frees every buffer and clears all statistics at once.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if and fbpa_pool_state.

module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int POOL_COUNT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    fbpa_req_if.sink          req,
    fbpa_rsp_if.source        rsp
);
    req_t in_reg;
    logic in_valid_reg;
    rsp_t out_reg;
    logic out_valid_reg;
    rsp_t result;
    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    fbpa_pool_state #(
        .POOL_COUNT (POOL_COUNT)
    ) u_pool_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (!out_valid_reg || rsp.ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg.req_type      <= req.req_type;
            in_reg.release_index <= req.release_index;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.granted         = out_reg.granted;
    assign rsp.grant_index     = out_reg.grant_index;
    assign rsp.acquired_total  = out_reg.acquired_total;
    assign rsp.released_total  = out_reg.released_total;
    assign rsp.exhausted_total = out_reg.exhausted_total;
    assign rsp.in_use          = out_reg.in_use;
    assign rsp.peak_in_use     = out_reg.peak_in_use;
    assign rsp.free_count      = out_reg.free_count;
endmodule

>>> sim/fixed_block_pool_allocator_core_tb.sv
// Testbench for fixed_block_pool_allocator_core: directed table then random requests,
// every result checked against the table or a cycle-free model of the pool and its statistics.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if and fixed_block_pool_allocator_core from the design folder.

module fixed_block_pool_allocator_core_tb;
    import fbpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL = 8;
    localparam int RANDOM_ITEMS = 1280;
    localparam int QUIET_FROM = 1130;
    localparam int HOLD_AT = 240;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_AT = 700;
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        req_t req;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    fbpa_req_if req_ch();
    fbpa_rsp_if rsp_ch();

    fixed_block_pool_allocator_core #(.POOL_COUNT(POOL)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model of the pool.
    logic [POOL-1:0]    free_bits;
    logic [TOTAL_W-1:0] acquire_cnt;
    logic [TOTAL_W-1:0] release_cnt;
    logic [TOTAL_W-1:0] exhaust_cnt;
    logic [USAGE_W-1:0] held_now;
    logic [USAGE_W-1:0] held_peak;

    rsp_t expected_stats_q[$];
    int   mismatches;
    bit   idle_on;
    bit   hold_request;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_pool_model();
        free_bits   = '1;
        acquire_cnt = '0;
        release_cnt = '0;
        exhaust_cnt = '0;
        held_now    = '0;
        held_peak   = '0;
    endfunction

    function automatic rsp_t stats(int g, int gi, int acq, int rel,
                                   int exh, int held, int peak, int fr);
        rsp_t s;
        s.granted         = 1'(g);
        s.grant_index     = GRANT_IDX_W'(gi);
        s.acquired_total  = TOTAL_W'(acq);
        s.released_total  = TOTAL_W'(rel);
        s.exhausted_total = TOTAL_W'(exh);
        s.in_use          = USAGE_W'(held);
        s.peak_in_use     = USAGE_W'(peak);
        s.free_count      = USAGE_W'(fr);
        return s;
    endfunction

    // Applies one request to the model and returns the statistics it reports.
    function automatic rsp_t pool_step(req_t r);
        rsp_t res;
        bit   found;
        res   = '0;
        found = 1'b0;
        case (r.req_type)
            REQ_ACQUIRE:
            begin
                if (free_bits != '0)
                begin
                    for (int k = 0; k < POOL; k++)
                    begin
                        if (!found && free_bits[k])
                        begin
                            found = 1'b1;
                            res.grant_index = k[GRANT_IDX_W-1:0];
                        end
                    end
                    free_bits[res.grant_index] = 1'b0;
                    res.granted = 1'b1;
                    acquire_cnt = acquire_cnt + 1;
                    held_now    = held_now + USAGE_W'(1);
                    if (held_now > held_peak)
                        held_peak = held_now;
                end
                else
                    exhaust_cnt = exhaust_cnt + 1;
            end
            REQ_RELEASE:
            begin
                if (r.release_index < POOL && !free_bits[r.release_index])
                begin
                    free_bits[r.release_index] = 1'b1;
                    release_cnt = release_cnt + 1;
                    if (held_now > 0)
                        held_now = held_now - USAGE_W'(1);
                end
            end
            REQ_RESET:
                clear_pool_model();
            default:
                ;
        endcase
        res.acquired_total  = acquire_cnt;
        res.released_total  = release_cnt;
        res.exhausted_total = exhaust_cnt;
        res.in_use          = held_now;
        res.peak_in_use     = held_peak;
        res.free_count      = USAGE_W'($countones(free_bits));
        return res;
    endfunction

    // Offers one request, waits for its transfer and records what must come back.
    task automatic offer(req_t r, bit typed, rsp_t want);
        rsp_t predicted;
        if (idle_on && !hold_request && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.req_type;
        req_ch.release_index <= r.release_index;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = pool_step(r);
        expected_stats_q.push_back(typed ? want : predicted);
    endtask

    // Result side: random stalls, plus one long hold that fills the block.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.granted         = rsp_ch.granted;
            got.grant_index     = rsp_ch.grant_index;
            got.acquired_total  = rsp_ch.acquired_total;
            got.released_total  = rsp_ch.released_total;
            got.exhausted_total = rsp_ch.exhausted_total;
            got.in_use          = rsp_ch.in_use;
            got.peak_in_use     = rsp_ch.peak_in_use;
            got.free_count      = rsp_ch.free_count;
            if (expected_stats_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: granted=%0b index=%0d",
                             $realtime, got.granted, got.grant_index);
            end
            else
            begin
                want = expected_stats_q.pop_front();
                if (got.granted !== want.granted || got.grant_index !== want.grant_index
                    || got.acquired_total !== want.acquired_total
                    || got.released_total !== want.released_total
                    || got.exhausted_total !== want.exhausted_total
                    || got.in_use !== want.in_use || got.peak_in_use !== want.peak_in_use
                    || got.free_count !== want.free_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: mismatch", $realtime);
                        $display("  expected g=%0b idx=%0d acq=%0d rel=%0d exh=%0d",
                                 want.granted, want.grant_index, want.acquired_total,
                                 want.released_total, want.exhausted_total);
                        $display("           use=%0d pk=%0d fr=%0d",
                                 want.in_use, want.peak_in_use, want.free_count);
                        $display("  actual   g=%0b idx=%0d acq=%0d rel=%0d exh=%0d",
                                 got.granted, got.grant_index, got.acquired_total,
                                 got.released_total, got.exhausted_total);
                        $display("           use=%0d pk=%0d fr=%0d",
                                 got.in_use, got.peak_in_use, got.free_count);
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        dir_row_t dir_rows[20];
        req_t     r;
        int       roll;
        int       acq_pct;
        int       k;

        mismatches   = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_ACQUIRE;
        req_ch.release_index <= '0;
        clear_pool_model();

        // Fill the pool, run it dry, release out of order, then reset it.
        dir_rows[0]  = '{'{REQ_UNUSED, 3'd0}, 1'b1, stats(0, 0, 0, 0, 0, 0, 0, 8)};
        dir_rows[1]  = '{'{REQ_RELEASE, 3'd0}, 1'b1, stats(0, 0, 0, 0, 0, 0, 0, 8)};
        dir_rows[2]  = '{'{REQ_ACQUIRE, 3'd7}, 1'b1, stats(1, 0, 1, 0, 0, 1, 1, 7)};
        for (int i = 3; i < 10; i++)
            dir_rows[i] = '{'{REQ_ACQUIRE, 3'd0}, 1'b0, '0};
        dir_rows[10] = '{'{REQ_ACQUIRE, 3'd0}, 1'b1, stats(0, 0, 8, 0, 1, 8, 8, 0)};
        dir_rows[11] = '{'{REQ_RELEASE, 3'd7}, 1'b0, '0};
        dir_rows[12] = '{'{REQ_RELEASE, 3'd7}, 1'b0, '0};
        dir_rows[13] = '{'{REQ_RELEASE, 3'd3}, 1'b0, '0};
        dir_rows[14] = '{'{REQ_ACQUIRE, 3'd0}, 1'b0, '0};
        dir_rows[15] = '{'{REQ_UNUSED, 3'd5}, 1'b0, '0};
        dir_rows[16] = '{'{REQ_RELEASE, 3'd0}, 1'b0, '0};
        dir_rows[17] = '{'{REQ_RESET, 3'd6}, 1'b1, stats(0, 0, 0, 0, 0, 0, 0, 8)};
        dir_rows[18] = '{'{REQ_RELEASE, 3'd5}, 1'b0, '0};
        dir_rows[19] = '{'{REQ_ACQUIRE, 3'd0}, 1'b0, '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == QUIET_FROM)
                idle_on = 1'b0;
            if (i == HOLD_AT)
                hold_request = 1'b1;
            if (i == DRAIN_AT)
            begin
                req_ch.valid <= 1'b0;
                while (expected_stats_q.size() != 0)
                    @(posedge clk);
            end
            // Phases alternate between filling, draining and a balanced mix.
            case ((i / 100) % 3)
                0: acq_pct = 70;
                1: acq_pct = 25;
                default: acq_pct = 47;
            endcase
            roll = $urandom_range(0, 99);
            r.release_index = REL_IDX_W'($urandom_range(0, 7));
            if (roll < 3)
                r.req_type = REQ_RESET;
            else if (roll < 6)
                r.req_type = REQ_UNUSED;
            else if (roll < 6 + acq_pct)
                r.req_type = REQ_ACQUIRE;
            else
            begin
                r.req_type = REQ_RELEASE;
                // Mostly free a buffer that is actually held.
                if (free_bits != '1 && $urandom_range(0, 3) != 0)
                begin
                    do
                        k = $urandom_range(0, POOL - 1);
                    while (free_bits[k]);
                    r.release_index = k[REL_IDX_W-1:0];
                end
            end
            offer(r, 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (expected_stats_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
